// ----- hdl/dtsbp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsbp_pkg
// Shared types, constants and helpers for the DTS burst packer.
// ----------------------------------------------------------------------------
package dtsbp_pkg;

    // raw 16-bit DTS sync markers as they appear in the first packet word
    localparam logic [31:0] MARK_RAW_BE = 32'h7FFE_8001;
    localparam logic [31:0] MARK_RAW_LE = 32'hFE7F_0180;

    // IEC 61937 preamble Pa/Pb
    localparam logic [7:0] SYNC_B0 = 8'h72;
    localparam logic [7:0] SYNC_B1 = 8'hF8;
    localparam logic [7:0] SYNC_B2 = 8'h1F;
    localparam logic [7:0] SYNC_B3 = 8'h4E;

    // burst data types for 16, 32 and 64 blocks
    localparam logic [7:0] BTYPE_NONE = 8'h00;
    localparam logic [7:0] BTYPE_16   = 8'h0B;
    localparam logic [7:0] BTYPE_32   = 8'h0C;
    localparam logic [7:0] BTYPE_64   = 8'h0D;

    localparam logic [15:0] MIN_PACKET_BYTES = 16'd96;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_MARKER = 3'd2;
    localparam logic [2:0] ST_BLOCKS = 3'd3;
    localparam logic [2:0] ST_LONG   = 3'd4;

    localparam int MAX_RES = 4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR,
        PH_DATA
    } t_phase;

    // one output frame slot
    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [2:0]  status;
        logic        fin;
        logic [10:0] pad;
        logic [14:0] fbytes;
    } t_res;

    // decoded DTS header and checks
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  blocks;
        logic [14:0] fsize;
        logic [7:0]  btype;
        logic [10:0] total;
        logic        be_src;
    } t_hdr;

    // data frame for one packet word; bytes at or past the frame end are zero
    function automatic t_res mk_data(input logic [31:0] w, input logic [16:0] base,
                                     input logic [14:0] fsize, input logic swap,
                                     input logic fin, input logic [10:0] pad);
        t_res       r;
        logic [7:0] b [4];
        for (int j = 0; j < 4; j++) begin
            b[j] = ((base + 17'(j)) < {2'b00, fsize}) ? w[31 - 8*j -: 8] : 8'h00;
        end
        r.b0     = swap ? b[1] : b[0];
        r.b1     = swap ? b[0] : b[1];
        r.b2     = swap ? b[3] : b[2];
        r.b3     = swap ? b[2] : b[3];
        r.status = ST_OK;
        r.fin    = fin;
        r.pad    = fin ? pad : 11'd0;
        r.fbytes = fsize;
        return r;
    endfunction

endpackage

// ----- hdl/dtsbp_if.sv -----
// ----------------------------------------------------------------------------
// dtsbp_if
// Valid/ready channel interfaces for packet words, frame slots and config.
// ----------------------------------------------------------------------------
interface dtsbp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        first;
    logic        last;
    logic [15:0] packet_bytes;

    modport source (output valid, word, first, last, packet_bytes, input ready);
    modport sink   (input valid, word, first, last, packet_bytes, output ready);
endinterface

interface dtsbp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [2:0]  status;
    logic        final_frame;
    logic [10:0] pad_frames;
    logic [14:0] frame_bytes;

    modport source (output valid, byte_zero, byte_one, byte_two, byte_three, status,
                    final_frame, pad_frames, frame_bytes, input ready);
    modport sink   (input valid, byte_zero, byte_one, byte_two, byte_three, status,
                    final_frame, pad_frames, frame_bytes, output ready);
endinterface

interface dtsbp_cfg_if;
    logic valid;
    logic ready;
    logic big_endian_out;

    modport source (output valid, big_endian_out, input ready);
    modport sink   (input valid, big_endian_out, output ready);
endinterface

// ----- hdl/dtsbp_hdr_dec.sv -----
// ----------------------------------------------------------------------------
// dtsbp_hdr_dec
// Decodes the DTS core header from the first two packet words and runs
// the packet checks in priority order.
// ----------------------------------------------------------------------------
module dtsbp_hdr_dec (
    input  logic [31:0]   i_held,
    input  logic [31:0]   i_word,
    input  logic          i_short,
    output dtsbp_pkg::t_hdr o_hdr
);
    import dtsbp_pkg::*;

    logic [15:0] h0;
    logic [15:0] h1;
    logic        is_be;
    logic        is_le;
    logic [12:0] total_w;
    logic [15:0] fs_p3;

    always_comb begin
        is_be = (i_held == MARK_RAW_BE);
        is_le = (i_held == MARK_RAW_LE);

        // header halfwords, byte swapped for a little-endian source
        if (is_be) begin
            h0 = i_word[31:16];
            h1 = i_word[15:0];
        end else begin
            h0 = {i_word[23:16], i_word[31:24]};
            h1 = {i_word[7:0], i_word[15:8]};
        end

        o_hdr.be_src = is_be;
        o_hdr.blocks = {1'b0, h0[8:2]} + 8'd1;
        o_hdr.fsize  = {1'b0, h0[1:0], h1[15:4]} + 15'd1;

        case (o_hdr.blocks)
            8'd16:   o_hdr.btype = BTYPE_16;
            8'd32:   o_hdr.btype = BTYPE_32;
            8'd64:   o_hdr.btype = BTYPE_64;
            default: o_hdr.btype = BTYPE_NONE;
        endcase

        // frames a burst holds after the two preamble frames
        total_w     = {o_hdr.blocks, 5'b0} - 13'd2;
        o_hdr.total = total_w[10:0];
        fs_p3       = {1'b0, o_hdr.fsize} + 16'd3;

        if (i_short) begin
            o_hdr.status = ST_SHORT;
        end else if (!is_be && !is_le) begin
            o_hdr.status = ST_MARKER;
        end else if (o_hdr.btype == BTYPE_NONE) begin
            o_hdr.status = ST_BLOCKS;
        end else if ({1'b0, fs_p3[15:2]} > {2'b00, total_w}) begin
            o_hdr.status = ST_LONG;
        end else begin
            o_hdr.status = ST_OK;
        end
    end

endmodule

// ----- hdl/dts_iec61937_burst_packer.sv -----
// ----------------------------------------------------------------------------
// dts_iec61937_burst_packer
// Packs raw DTS core frames into IEC 61937 bursts of 16, 32 or 64 blocks.
// ----------------------------------------------------------------------------
// Takes one packet word per cycle while nothing stalls. Each accepted word
// is worked out in the cycle it arrives and its frame slots land in a
// four-entry result bundle that drains through an output register, one
// slot per cycle while the receiver keeps up. Most words give one slot or
// none; the second word of a packet gives sync, type/length and up to two
// data slots, so the word after it waits while the bundle drains. The
// output register lets a new word in while the last slot waits downstream.
// The final slot reports pad_frames, the zero frames the serializer must add
// to fill the burst. Config writes are always accepted and must be made
// while the block is idle.
module dts_iec61937_burst_packer (
    input  logic i_clk,
    input  logic i_rst_n,
    dtsbp_in_if.sink    i_in,
    dtsbp_out_if.source o_out,
    dtsbp_cfg_if.sink   i_cfg
);
    import dtsbp_pkg::*;

    // packet state
    t_phase      r_phase, n_phase;
    logic [31:0] r_held, n_held;
    logic [12:0] r_wc, n_wc;
    logic [6:0]  r_bt, n_bt;
    logic [14:0] r_fs, n_fs;
    logic        r_swap, n_swap;
    logic        r_short, n_short;
    logic        r_be_out;

    // result bundle and output register
    t_res        r_bnd [MAX_RES];
    t_res        bnd   [MAX_RES];
    logic [2:0]  r_left, n_cnt;
    logic [1:0]  r_idx;
    t_res        r_out;
    logic        r_ov;

    logic        accept;
    logic        mv;
    logic [31:0] hw;
    logic [31:0] wv;
    logic        sp;
    logic        do_hdr;
    logic        fin;
    logic        swap_new;
    logic [11:0] total_r;
    logic [13:0] pad_r;
    logic [12:0] k1;
    logic [16:0] base;
    t_hdr        hdr;

    // config register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_be_out <= 1'b0;
        end else if (i_cfg.valid) begin
            r_be_out <= i_cfg.big_endian_out;
        end
    end

    // handshakes
    assign mv          = (r_left != 3'd0) && (!r_ov || o_out.ready);
    assign i_in.ready  = (r_left == 3'd0) || ((r_left == 3'd1) && mv);
    assign accept      = i_in.valid && i_in.ready;

    // header words: a one-word packet takes its second word as zero
    assign hw     = i_in.first ? i_in.word : r_held;
    assign wv     = i_in.first ? 32'd0 : i_in.word;
    assign sp     = i_in.first ? (i_in.packet_bytes < MIN_PACKET_BYTES) : r_short;
    assign do_hdr = i_in.first ? i_in.last : (r_phase == PH_HDR);

    dtsbp_hdr_dec u_hdr_dec (
        .i_held  (hw),
        .i_word  (wv),
        .i_short (sp),
        .o_hdr   (hdr)
    );

    // next state and result bundle for the word on the input
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_wc     = r_wc;
        n_bt     = r_bt;
        n_fs     = r_fs;
        n_swap   = r_swap;
        n_short  = r_short;
        n_cnt    = 3'd0;
        fin      = 1'b0;
        swap_new = hdr.be_src && !r_be_out;
        total_r  = {r_bt, 5'b0} - 12'd2;
        k1       = r_wc + 13'd1;
        base     = {2'b00, r_wc, 2'b00};
        pad_r    = {2'b00, total_r} - {1'b0, k1};
        for (int i = 0; i < MAX_RES; i++) begin
            bnd[i] = '0;
        end

        if (i_in.first) begin
            n_held  = i_in.word;
            n_short = sp;
            n_wc    = 13'd1;
            n_bt    = 7'd0;
            n_fs    = 15'd0;
            n_swap  = 1'b0;
            n_phase = PH_HDR;
        end

        if (do_hdr) begin
            n_bt = hdr.blocks[6:0];
            n_fs = hdr.fsize;
            if (hdr.status != ST_OK) begin
                // error: one all-zero final slot
                bnd[0].status = hdr.status;
                bnd[0].fin    = 1'b1;
                n_cnt         = 3'd1;
                n_phase       = PH_IDLE;
            end else begin
                n_swap = swap_new;
                if (r_be_out) begin
                    bnd[0] = '{SYNC_B1, SYNC_B0, SYNC_B3, SYNC_B2, ST_OK, 1'b0, 11'd0,
                               hdr.fsize};
                    bnd[1] = '{8'h00, hdr.btype, hdr.fsize[12:5], {hdr.fsize[4:0], 3'b0},
                               ST_OK, 1'b0, 11'd0, hdr.fsize};
                end else begin
                    bnd[0] = '{SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3, ST_OK, 1'b0, 11'd0,
                               hdr.fsize};
                    bnd[1] = '{hdr.btype, 8'h00, {hdr.fsize[4:0], 3'b0}, hdr.fsize[12:5],
                               ST_OK, 1'b0, 11'd0, hdr.fsize};
                end
                if (hdr.fsize <= 15'd4) begin
                    // whole frame sits in the marker word
                    bnd[2]  = mk_data(hw, 17'd0, hdr.fsize, swap_new, 1'b1,
                                      hdr.total - 11'd1);
                    n_cnt   = 3'd3;
                    n_phase = PH_IDLE;
                end else begin
                    fin     = i_in.last || (hdr.fsize <= 15'd8);
                    bnd[2]  = mk_data(hw, 17'd0, hdr.fsize, swap_new, 1'b0, 11'd0);
                    bnd[3]  = mk_data(wv, 17'd4, hdr.fsize, swap_new, fin,
                                      hdr.total - 11'd2);
                    n_cnt   = 3'd4;
                    n_wc    = 13'd2;
                    n_phase = fin ? PH_IDLE : PH_DATA;
                end
            end
        end else if (!i_in.first && (r_phase == PH_DATA)) begin
            // streaming data word
            fin     = i_in.last || ({2'b00, k1, 2'b00} >= {2'b00, r_fs});
            bnd[0]  = mk_data(i_in.word, base, r_fs, r_swap, fin, pad_r[10:0]);
            n_cnt   = 3'd1;
            n_wc    = k1;
            n_phase = fin ? PH_IDLE : PH_DATA;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_wc    <= '0;
            r_bt    <= '0;
            r_fs    <= '0;
            r_swap  <= 1'b0;
            r_short <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_wc    <= n_wc;
            r_bt    <= n_bt;
            r_fs    <= n_fs;
            r_swap  <= n_swap;
            r_short <= n_short;
        end
    end

    // result bundle: load on accept, drain one slot per move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 2'd0;
        end else if (accept) begin
            r_left <= n_cnt;
            r_idx  <= 2'd0;
        end else if (mv) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_bnd[i] <= bnd[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= mv || (r_ov && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv) begin
            r_out <= r_bnd[r_idx];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.byte_zero   = r_out.b0;
    assign o_out.byte_one    = r_out.b1;
    assign o_out.byte_two    = r_out.b2;
    assign o_out.byte_three  = r_out.b3;
    assign o_out.status      = r_out.status;
    assign o_out.final_frame = r_out.fin;
    assign o_out.pad_frames  = r_out.pad;
    assign o_out.frame_bytes = r_out.fbytes;

endmodule

// ----- bench/dtsbp_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsbp_sb_pkg
// Predictor and result scoreboard for the DTS to IEC 61937 burst packer bench.
// ----------------------------------------------------------------------------
package dtsbp_sb_pkg;

    import dtsbp_pkg::*;

    class burst_slot_scoreboard;

        // output byte order register as last written
        logic        be_out;

        // packer state mirror
        logic [31:0] held_word;
        logic [12:0] word_idx;
        int          blocks;
        logic [14:0] fsize;
        logic        swap;
        t_phase      ph;
        logic        short_pkt;

        // frame slots still owed by the block, oldest first
        t_res        due_slots[$];

        int          mismatches;
        int          slots_checked;
        int          bursts_framed;
        int          error_slots;

        function new();
            be_out        = 1'b0;
            held_word     = '0;
            word_idx      = '0;
            blocks        = 0;
            fsize         = '0;
            swap          = 1'b0;
            ph            = PH_IDLE;
            short_pkt     = 1'b0;
            mismatches    = 0;
            slots_checked = 0;
            bursts_framed = 0;
            error_slots   = 0;
        endfunction

        function void write_config(logic value);
            be_out = value;
        endfunction

        function int pending();
            return due_slots.size();
        endfunction

        function void owe_slot(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                               logic [7:0] b3, logic [2:0] st, logic fin,
                               logic [10:0] pad, logic [14:0] fb);
            t_res r;
            r.b0     = b0;
            r.b1     = b1;
            r.b2     = b2;
            r.b3     = b3;
            r.status = st;
            r.fin    = fin;
            r.pad    = pad;
            r.fbytes = fb;
            due_slots.push_back(r);
        endfunction

        // data slot for a word whose first byte sits at offset base in the frame
        function void owe_data(logic [31:0] w, int base, logic fin, int done);
            logic [7:0]  b [4];
            logic [10:0] pad;
            int          j;
            pad = fin ? 11'(blocks * 32 - 2 - done) : 11'd0;
            for (j = 0; j < 4; j++) begin
                b[j] = (base + j < int'(fsize)) ? w[31 - 8*j -: 8] : 8'h00;
            end
            if (swap) begin
                owe_slot(b[1], b[0], b[3], b[2], ST_OK, fin, pad, fsize);
            end else begin
                owe_slot(b[0], b[1], b[2], b[3], ST_OK, fin, pad, fsize);
            end
        endfunction

        // second packet word: decode the header, run the checks, open the burst
        function void decode_header(logic [31:0] w, logic is_last);
            logic [15:0] h0;
            logic [15:0] h1;
            logic [7:0]  btype;
            logic [2:0]  st;
            logic        fin;
            if (held_word == MARK_RAW_BE) begin
                h0 = w[31:16];
                h1 = w[15:0];
            end else begin
                h0 = {w[23:16], w[31:24]};
                h1 = {w[7:0], w[15:8]};
            end
            blocks = int'(h0[8:2]) + 1;
            fsize  = 15'({h0[1:0], h1[15:4]}) + 15'd1;
            case (blocks)
                16:      btype = BTYPE_16;
                32:      btype = BTYPE_32;
                64:      btype = BTYPE_64;
                default: btype = BTYPE_NONE;
            endcase

            st = ST_OK;
            if (short_pkt) begin
                st = ST_SHORT;
            end else if (held_word != MARK_RAW_BE && held_word != MARK_RAW_LE) begin
                st = ST_MARKER;
            end else if (btype == BTYPE_NONE) begin
                st = ST_BLOCKS;
            end else if ((int'(fsize) + 3) / 4 > blocks * 32 - 2) begin
                st = ST_LONG;
            end
            if (st != ST_OK) begin
                owe_slot(8'h00, 8'h00, 8'h00, 8'h00, st, 1'b1, 11'd0, 15'd0);
                error_slots++;
                ph = PH_IDLE;
                return;
            end

            bursts_framed++;
            swap = (held_word == MARK_RAW_BE) && !be_out;
            // sync slot, then burst type and length in bits
            if (be_out) begin
                owe_slot(SYNC_B1, SYNC_B0, SYNC_B3, SYNC_B2, ST_OK, 1'b0, 11'd0, fsize);
                owe_slot(8'h00, btype, fsize[12:5], {fsize[4:0], 3'b000},
                         ST_OK, 1'b0, 11'd0, fsize);
            end else begin
                owe_slot(SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3, ST_OK, 1'b0, 11'd0, fsize);
                owe_slot(btype, 8'h00, {fsize[4:0], 3'b000}, fsize[12:5],
                         ST_OK, 1'b0, 11'd0, fsize);
            end

            // whole frame inside the held word
            if (fsize <= 15'd4) begin
                owe_data(held_word, 0, 1'b1, 1);
                ph = PH_IDLE;
                return;
            end
            owe_data(held_word, 0, 1'b0, 1);
            fin = is_last || (fsize <= 15'd8);
            owe_data(w, 4, fin, 2);
            word_idx = 13'd2;
            ph = fin ? PH_IDLE : PH_DATA;
        endfunction

        // accepted input transaction; returns 0 when the block ignores the word
        function bit pack_word(logic [31:0] w, logic is_first, logic is_last,
                               logic [15:0] pbytes);
            int  k;
            logic fin;
            if (is_first) begin
                held_word = w;
                short_pkt = (pbytes < MIN_PACKET_BYTES);
                word_idx  = 13'd1;
                blocks    = 0;
                fsize     = '0;
                swap      = 1'b0;
                ph        = PH_HDR;
                // one-word packet: missing header word reads as zero
                if (is_last) begin
                    decode_header(32'h0, 1'b1);
                end
                return 1'b1;
            end
            if (ph == PH_HDR) begin
                decode_header(w, is_last);
                return 1'b1;
            end
            if (ph != PH_DATA) begin
                return 1'b0;
            end
            k   = int'(word_idx);
            fin = is_last || ((k + 1) * 4 >= int'(fsize));
            owe_data(w, k * 4, fin, k + 1);
            word_idx = 13'(k + 1);
            if (fin) begin
                ph = PH_IDLE;
            end
            return 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("slot error %0d: %s", mismatches, msg);
            end
        endfunction

        // accepted output transaction against the oldest owed slot
        function void check_slot(t_res got);
            t_res  want;
            string diff;
            slots_checked++;
            if (due_slots.size() == 0) begin
                flag($sformatf("unexpected slot %p", got));
                return;
            end
            want = due_slots.pop_front();
            diff = "";
            if (got.b0 !== want.b0)
                diff = {diff, $sformatf(" byte_zero exp %02h got %02h", want.b0, got.b0)};
            if (got.b1 !== want.b1)
                diff = {diff, $sformatf(" byte_one exp %02h got %02h", want.b1, got.b1)};
            if (got.b2 !== want.b2)
                diff = {diff, $sformatf(" byte_two exp %02h got %02h", want.b2, got.b2)};
            if (got.b3 !== want.b3)
                diff = {diff, $sformatf(" byte_three exp %02h got %02h", want.b3, got.b3)};
            if (got.status !== want.status)
                diff = {diff, $sformatf(" status exp %0d got %0d", want.status, got.status)};
            if (got.fin !== want.fin)
                diff = {diff, $sformatf(" final_frame exp %0b got %0b", want.fin, got.fin)};
            if (got.pad !== want.pad)
                diff = {diff, $sformatf(" pad_frames exp %0d got %0d", want.pad, got.pad)};
            if (got.fbytes !== want.fbytes)
                diff = {diff, $sformatf(" frame_bytes exp %0d got %0d",
                                        want.fbytes, got.fbytes)};
            if (diff != "") begin
                flag($sformatf("slot %0d:%s", slots_checked, diff));
            end
        endfunction

        // anything still owed at the end never showed up
        function void flush_missing();
            t_res want;
            while (due_slots.size() != 0) begin
                want = due_slots.pop_front();
                flag($sformatf("missing slot %p", want));
            end
        endfunction

    endclass

endpackage

// ----- bench/dts_iec61937_burst_packer_tb.sv -----
// ----------------------------------------------------------------------------
// dts_iec61937_burst_packer_tb
// Self-checking bench for the DTS to IEC 61937 burst packer.
// ----------------------------------------------------------------------------
// Drives packets of words through the input channel, predicts every frame
// slot in a scoreboard and checks each output transaction against it. A
// directed pass covers the header checks and frame edge cases, then four
// random passes mix well-formed packets with noise under different sender
// idle and receiver stall rates, with one long downstream hold to back the
// block up. The output byte order is changed between passes.
module dts_iec61937_burst_packer_tb;

    import dtsbp_pkg::*;
    import dtsbp_sb_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PASS_WORDS  = 94;

    // 14-bit DTS markers, never accepted as raw
    localparam logic [31:0] MARK_14_BE = 32'h1FFF_E800;
    localparam logic [31:0] MARK_14_LE = 32'hFF1F_00E8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dtsbp_in_if  in_ch ();
    dtsbp_out_if out_ch ();
    dtsbp_cfg_if cfg_ch ();

    dts_iec61937_burst_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    burst_slot_scoreboard board;

    int words_taken;
    int send_idle_pct;
    int sink_stall_pct;
    bit long_hold;

    always #5 i_clk = ~i_clk;

    // monitor: outputs are checked before the same-edge input is predicted
    always @(posedge i_clk) begin : edge_monitor
        t_res got;
        if (i_rst_n) begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.b0     = out_ch.byte_zero;
                got.b1     = out_ch.byte_one;
                got.b2     = out_ch.byte_two;
                got.b3     = out_ch.byte_three;
                got.status = out_ch.status;
                got.fin    = out_ch.final_frame;
                got.pad    = out_ch.pad_frames;
                got.fbytes = out_ch.frame_bytes;
                board.check_slot(got);
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                if (board.pack_word(in_ch.word, in_ch.first, in_ch.last,
                                    in_ch.packet_bytes)) begin
                    words_taken++;
                end
            end
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
                board.write_config(cfg_ch.big_endian_out);
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin : sink_side
        int hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                hold      = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // watchdog: too long without any transaction
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout after %0d quiet cycles", IDLE_LIMIT);
        $display("dts_iec61937_burst_packer regression: fail");
        $finish;
    end

    // one input transaction, with a random gap in front; returns at acceptance
    task automatic send_word(logic [31:0] w, logic is_first, logic is_last,
                             logic [15:0] pbytes);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.word         <= w;
        in_ch.first        <= is_first;
        in_ch.last         <= is_last;
        in_ch.packet_bytes <= pbytes;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    endtask

    // stop sending and wait until every owed slot is out
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_byte_order(logic be);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.big_endian_out <= be;
        do @(posedge i_clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
        cfg_ch.valid <= 1'b0;
    endtask

    // header word in the source byte order of the marker (little-endian only for the raw LE marker)
    function automatic logic [31:0] header_for(logic [31:0] marker, int blk, int fsz);
        logic [15:0] h0;
        logic [15:0] h1;
        logic [13:0] fm;
        logic [6:0]  top_bits;
        logic [3:0]  low_bits;
        fm       = 14'(fsz - 1);
        top_bits = 7'($urandom_range(127));
        low_bits = 4'($urandom_range(15));
        h0       = {top_bits, 7'(blk - 1), fm[13:12]};
        h1       = {fm[11:0], low_bits};
        if (marker == MARK_RAW_LE) begin
            return {h0[7:0], h0[15:8], h1[7:0], h1[15:8]};
        end
        return {h0, h1};
    endfunction

    task automatic send_packet(logic [31:0] marker, int blk, int fsz, int nwords,
                               bit with_last, logic [15:0] pbytes);
        logic [31:0] w;
        int          i;
        for (i = 0; i < nwords; i++) begin
            if (i == 0) begin
                w = marker;
            end else if (i == 1) begin
                w = header_for(marker, blk, fsz);
            end else begin
                w = $urandom();
            end
            send_word(w, i == 0, with_last && (i == nwords - 1),
                      (i == 0) ? pbytes : 16'($urandom()));
        end
    endtask

    // mostly well-formed packets, some broken ones, a little noise
    task automatic random_traffic();
        int          sel;
        int          blk;
        int          fsz;
        int          cap;
        int          natural;
        int          nwords;
        logic [31:0] marker;
        logic [15:0] pbytes;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) begin
                send_word($urandom(), $urandom_range(9) == 0, $urandom_range(3) == 0,
                          16'($urandom()));
            end
            return;
        end

        sel = $urandom_range(19);
        if (sel < 9) begin
            marker = MARK_RAW_BE;
        end else if (sel < 18) begin
            marker = MARK_RAW_LE;
        end else if (sel == 18) begin
            marker = $urandom_range(1) ? MARK_14_BE : MARK_14_LE;
        end else begin
            marker = $urandom();
        end

        blk = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : (16 << $urandom_range(2));

        // largest frame the burst holds, and one byte past it
        cap = (blk * 32 - 2) * 4;
        sel = $urandom_range(19);
        if (sel < 16) begin
            fsz = $urandom_range(1, 64);
        end else if (sel < 18) begin
            fsz = $urandom_range(1, 16384);
        end else if (sel == 18) begin
            fsz = (cap > 16384) ? 16384 : cap;
        end else begin
            fsz = (cap + 1 > 16384) ? 16384 : cap + 1;
        end

        natural = (fsz <= 8) ? 2 : (fsz + 3) / 4;
        sel     = $urandom_range(9);
        if (natural > 24) begin
            nwords = $urandom_range(1, 12);
        end else if (sel < 7) begin
            nwords = natural;
        end else if (sel == 7) begin
            nwords = natural + $urandom_range(1, 3);
        end else begin
            nwords = $urandom_range(1, natural);
        end

        pbytes = ($urandom_range(11) == 0) ? 16'($urandom_range(0, 95))
                                           : 16'($urandom_range(96, 65535));
        send_packet(marker, blk, fsz, nwords, $urandom_range(19) != 0, pbytes);
    endtask

    initial begin : main_flow
        int p;
        int stop_at;
        board = new();

        in_ch.valid           = 1'b0;
        in_ch.word            = '0;
        in_ch.first           = 1'b0;
        in_ch.last            = 1'b0;
        in_ch.packet_bytes    = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.big_endian_out = 1'b0;
        send_idle_pct         = 0;
        sink_stall_pct        = 0;
        long_hold             = 1'b0;
        words_taken           = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: frame sizes at the short end, every header check
        send_packet(MARK_RAW_BE, 16, 3, 2, 1'b1, 16'hFFFF);          // frame in held word
        send_packet(MARK_RAW_LE, 32, 8, 2, 1'b1, MIN_PACKET_BYTES);  // done at header word
        send_packet(MARK_RAW_BE, 64, 10, 4, 1'b1, 16'd1000);         // word past frame end
        send_packet(MARK_RAW_BE, 16, 40, 2, 1'b1, 16'd0);            // packet too short
        send_packet(MARK_14_BE, 16, 40, 2, 1'b1, 16'd500);           // 14-bit marker
        send_packet(MARK_RAW_LE, 128, 40, 2, 1'b1, 16'd500);         // bad block count
        send_packet(MARK_RAW_LE, 16, 16384, 2, 1'b1, 16'd65535);     // frame too long
        send_packet(MARK_RAW_BE, 16, 40, 1, 1'b1, 16'd200);          // one-word packet
        send_word($urandom(), 1'b0, 1'b0, 16'($urandom()));          // words while idle
        send_word($urandom(), 1'b0, 1'b1, 16'($urandom()));
        wait_drain();
        set_byte_order(1'b1);
        send_packet(MARK_RAW_BE, 32, 30, 2, 1'b0, 16'd300);          // abandoned by next first
        send_packet(MARK_RAW_LE, 16, 40, 4, 1'b1, 16'd300);          // ends early
        send_packet(MARK_RAW_BE, 64, 5, 2, 1'b1, 16'd300);

        // random passes: none, sender idle, receiver stall, both
        for (p = 0; p < 4; p++) begin
            wait_drain();
            set_byte_order(p[0]);
            send_idle_pct  = (p == 1) ? 48 : (p == 3) ? 33 : 0;
            sink_stall_pct = (p == 2) ? 48 : (p == 3) ? 33 : 0;
            if (p == 0) begin
                long_hold = 1'b1;
            end
            stop_at = words_taken + PASS_WORDS;
            while (words_taken < stop_at) begin
                random_traffic();
            end
            // close with a complete packet so the block is idle for the next write
            send_packet(MARK_RAW_LE, 16, 24, 6, 1'b1, 16'd1000);
        end

        wait_drain();
        board.flush_missing();

        $display("covered %0d packet words and %0d output slots: %0d bursts, %0d error slots",
                 words_taken, board.slots_checked, board.bursts_framed, board.error_slots);
        $display("both output byte orders, four idle/stall mixes, one long downstream hold");
        if (board.mismatches == 0) begin
            $display("dts_iec61937_burst_packer regression: pass");
        end else begin
            $display("dts_iec61937_burst_packer regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dtsbp_pkg.sv
hdl/dtsbp_if.sv
hdl/dtsbp_hdr_dec.sv
hdl/dts_iec61937_burst_packer.sv
bench/dtsbp_sb_pkg.sv
bench/dts_iec61937_burst_packer_tb.sv
